@@ sv/scfd_pkg.sv @@
// Package with shared constants and types for the sum-checked frame deframer.
package scfd_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h5A;
   localparam logic [7:0] HDR_SECOND = 8'hA5;
   localparam logic [7:0] MIN_LEN    = 8'd4;

   localparam logic [7:0] POS_HDR2 = 8'd1;
   localparam logic [7:0] POS_LEN  = 8'd2;
   localparam logic [7:0] POS_BODY = 8'd3;

   // Parser phases.
   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_HDR2 = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;
   localparam logic [1:0] PH_BODY = 2'd3;

   // Register map, by word index.
   localparam logic REG_FIXED_OVERHEAD = 1'b0;
   localparam logic REG_MAX_FRAME_LEN  = 1'b1;

   localparam logic [7:0] FIXED_OVERHEAD_RST = 8'd6;
   localparam logic [8:0] MAX_FRAME_LEN_RST  = 9'd256;

   typedef struct packed {
      logic [1:0] phase;
      logic [7:0] position;
      logic [7:0] len_byte;
      logic [7:0] running_sum;
   } parse_state_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] frame_byte;
      logic [7:0] byte_position;
      logic       frame_last;
      logic       checksum_ok;
      logic       frame_abort;
   } result_type;

endpackage

@@ sv/scfd_step.sv @@
// Next-state and result logic for one received byte of the frame parser.
module scfd_step (
   input  scfd_pkg::parse_state_type cur_state,
   input  logic [7:0]                rx_byte,
   input  logic [7:0]                fixed_overhead,
   input  logic [8:0]                max_frame_len,
   output scfd_pkg::parse_state_type nxt_state,
   output scfd_pkg::result_type      result
);

   logic [7:0] sum_add;
   logic [8:0] pos_plus1;
   logic       len_good;

   assign sum_add   = cur_state.running_sum + rx_byte;
   assign pos_plus1 = {1'b0, cur_state.position} + 9'd1;
   assign len_good  = (rx_byte > fixed_overhead) && ({1'b0, rx_byte} < max_frame_len) &&
                      (rx_byte >= scfd_pkg::MIN_LEN);

   always_comb begin
      nxt_state            = cur_state;
      result.emit          = 1'b0;
      result.frame_byte    = rx_byte;
      result.byte_position = cur_state.position;
      result.frame_last    = 1'b0;
      result.checksum_ok   = 1'b0;
      result.frame_abort   = 1'b0;

      case (cur_state.phase)
         scfd_pkg::PH_HUNT: begin
            // Noise between frames is dropped without a result.
            if (rx_byte == scfd_pkg::HDR_FIRST) begin
               result.emit           = 1'b1;
               result.byte_position  = '0;
               nxt_state.running_sum = rx_byte;
               nxt_state.position    = scfd_pkg::POS_HDR2;
               nxt_state.phase       = scfd_pkg::PH_HDR2;
            end
         end
         scfd_pkg::PH_HDR2: begin
            result.emit          = 1'b1;
            result.byte_position = scfd_pkg::POS_HDR2;
            if (rx_byte != scfd_pkg::HDR_SECOND) begin
               result.frame_abort    = 1'b1;
               nxt_state.phase       = scfd_pkg::PH_HUNT;
               nxt_state.position    = '0;
               nxt_state.running_sum = '0;
            end else begin
               nxt_state.running_sum = sum_add;
               nxt_state.position    = scfd_pkg::POS_LEN;
               nxt_state.phase       = scfd_pkg::PH_LEN;
            end
         end
         scfd_pkg::PH_LEN: begin
            result.emit          = 1'b1;
            result.byte_position = scfd_pkg::POS_LEN;
            nxt_state.len_byte   = rx_byte;
            if (len_good) begin
               nxt_state.running_sum = sum_add;
               nxt_state.position    = scfd_pkg::POS_BODY;
               nxt_state.phase       = scfd_pkg::PH_BODY;
            end else begin
               result.frame_abort    = 1'b1;
               nxt_state.phase       = scfd_pkg::PH_HUNT;
               nxt_state.position    = '0;
               nxt_state.running_sum = '0;
            end
         end
         default: begin
            result.emit = 1'b1;
            if (pos_plus1 >= {1'b0, cur_state.len_byte}) begin
               // Checksum byte closes the frame.
               result.frame_last     = 1'b1;
               result.checksum_ok    = (rx_byte == cur_state.running_sum);
               nxt_state.phase       = scfd_pkg::PH_HUNT;
               nxt_state.position    = '0;
               nxt_state.running_sum = '0;
            end else begin
               nxt_state.running_sum = sum_add;
               nxt_state.position    = pos_plus1[7:0];
            end
         end
      endcase
   end

endmodule

@@ sv/sum_checked_frame_deframer.sv @@
// Top level of the sum-checked frame deframer: byte intake, parser state and result register.
//
//   Channel | Ports       | Direction | Moves
//   --------+-------------+-----------+-----------------------------------------------
//   request | req_*       | in        | one received byte per transfer
//   result  | rsp_*       | out       | one frame byte with position and status flags
//   config  | csr_*       | in/out    | APB-style access to the two length bounds
//
// A received byte sits in the input register while the parser works on it, and its
// result is then written into the result register and offered from there. A new byte
// can be taken in every cycle unless a stalled result holds the parser.
// Reset is synchronous and active high; it clears the parser, both valid flags and
// restores the register defaults. A stalled result holds the parser, and the input
// register still takes one more byte while the result waits.
module sum_checked_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   // Received byte stream.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // Parsed frame bytes.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic [7:0]  rsp_byte_position,
   output logic        rsp_frame_last,
   output logic        rsp_checksum_ok,
   output logic        rsp_frame_abort,
   // Configuration registers.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers.
   logic [7:0] fixed_overhead_ff, fixed_overhead_in;
   logic [8:0] max_frame_len_ff, max_frame_len_in;
   logic       csr_write;

   // Input register.
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Parser state and result register.
   scfd_pkg::parse_state_type state_ff, state_in, step_state;
   scfd_pkg::result_type      step_result;
   scfd_pkg::result_type      rsp_ff, rsp_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic                      stage_go;

   // The APB write completes in the access phase; pready is tied high.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      fixed_overhead_in = fixed_overhead_ff;
      max_frame_len_in  = max_frame_len_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            scfd_pkg::REG_FIXED_OVERHEAD: fixed_overhead_in = csr_pwdata[7:0];
            scfd_pkg::REG_MAX_FRAME_LEN:  max_frame_len_in  = csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         scfd_pkg::REG_FIXED_OVERHEAD: csr_prdata = {24'd0, fixed_overhead_ff};
         scfd_pkg::REG_MAX_FRAME_LEN:  csr_prdata = {23'd0, max_frame_len_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   scfd_step u_step (
      .cur_state      (state_ff),
      .rx_byte        (in_byte_ff),
      .fixed_overhead (fixed_overhead_ff),
      .max_frame_len  (max_frame_len_ff),
      .nxt_state      (step_state),
      .result         (step_result)
   );

   // The held byte moves through the parser when the result register can take its
   // result, or when the byte is hunting noise that gives no result at all.
   assign stage_go  = in_vld_ff && (!step_result.emit || !rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || stage_go;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (req_valid && req_ready) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_rx_byte;
      end else if (stage_go) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      state_in   = stage_go ? step_state : state_ff;
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      if (stage_go && step_result.emit) begin
         rsp_in     = step_result;
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_overhead_ff <= scfd_pkg::FIXED_OVERHEAD_RST;
         max_frame_len_ff  <= scfd_pkg::MAX_FRAME_LEN_RST;
         in_vld_ff         <= 1'b0;
         rsp_vld_ff        <= 1'b0;
         state_ff          <= '{phase: scfd_pkg::PH_HUNT, position: 8'd0,
                                len_byte: 8'd0, running_sum: 8'd0};
      end else begin
         fixed_overhead_ff <= fixed_overhead_in;
         max_frame_len_ff  <= max_frame_len_in;
         in_vld_ff         <= in_vld_in;
         rsp_vld_ff        <= rsp_vld_in;
         state_ff          <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_frame_byte    = rsp_ff.frame_byte;
   assign rsp_byte_position = rsp_ff.byte_position;
   assign rsp_frame_last    = rsp_ff.frame_last;
   assign rsp_checksum_ok   = rsp_ff.checksum_ok;
   assign rsp_frame_abort   = rsp_ff.frame_abort;

endmodule

@@ sv/scfd_checker.sv @@
// Port-level checks for the sum-checked frame deframer and their binding.
module scfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_frame_byte,
   input logic [7:0] rsp_byte_position,
   input logic       rsp_frame_last,
   input logic       rsp_checksum_ok,
   input logic       rsp_frame_abort
);

   // A stalled result keeps its transfer intact.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte) &&
                                 $stable(rsp_byte_position))
      else $error("result changed while stalled");

   // A checksum verdict is only given on the closing byte of a frame.
   a_ok_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_ok |-> rsp_frame_last && !rsp_frame_abort)
      else $error("checksum_ok outside the last byte");

   // Aborts happen only at the second header byte or the length byte.
   a_abort_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_abort |->
         (rsp_byte_position == 8'd1 || rsp_byte_position == 8'd2) && !rsp_frame_last)
      else $error("abort at an unexpected position");

   // The closing byte follows at least the header and the length byte.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_byte_position >= 8'd3)
      else $error("frame closed before the body");

   // No result is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sum_checked_frame_deframer scfd_checker u_scfd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_frame_byte    (rsp_frame_byte),
   .rsp_byte_position (rsp_byte_position),
   .rsp_frame_last    (rsp_frame_last),
   .rsp_checksum_ok   (rsp_checksum_ok),
   .rsp_frame_abort   (rsp_frame_abort)
);

@@ test/scfd_frame_checker.sv @@
// Checker that follows the deframer's byte and result streams, predicts each result and compares.
`timescale 1ns / 100ps
module scfd_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_frame_byte,
   input  logic [7:0]  rsp_byte_position,
   input  logic        rsp_frame_last,
   input  logic        rsp_checksum_ok,
   input  logic        rsp_frame_abort,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_results,
   output int          bytes_taken,
   output int          results_taken,
   output int          good_frames,
   output int          bad_frames,
   output int          aborted_frames
);

   localparam int MAX_REPORTS = 40;

   // Shadow of the parser state and of the two length bounds.
   logic [1:0] parse_phase;
   logic [7:0] next_pos;
   logic [7:0] shadow_len;
   logic [7:0] byte_sum;
   logic [7:0] overhead_cfg;
   logic [8:0] max_len_cfg;

   scfd_pkg::result_type expected_frame_bytes[$];
   scfd_pkg::result_type predicted;

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want_val);
      if (fail_count < MAX_REPORTS) begin
         $display("MISMATCH at result %0d: %s got 0x%h, expected 0x%h",
                  results_taken, what, got, want_val);
      end
      fail_count++;
   endtask

   task automatic restart_hunt();
      parse_phase = scfd_pkg::PH_HUNT;
      next_pos    = '0;
      byte_sum    = '0;
   endtask

   // Moves the shadow parser by one received byte; res.emit tells whether a result follows.
   task automatic advance_parser(input logic [7:0] rx, output scfd_pkg::result_type res);
      res = '0;
      res.frame_byte = rx;
      case (parse_phase)
         scfd_pkg::PH_HUNT: begin
            // Anything but the first header byte is dropped silently.
            if (rx == scfd_pkg::HDR_FIRST) begin
               res.emit    = 1'b1;
               byte_sum    = rx;
               next_pos    = scfd_pkg::POS_HDR2;
               parse_phase = scfd_pkg::PH_HDR2;
            end
         end
         scfd_pkg::PH_HDR2: begin
            res.emit          = 1'b1;
            res.byte_position = scfd_pkg::POS_HDR2;
            if (rx != scfd_pkg::HDR_SECOND) begin
               res.frame_abort = 1'b1;
               restart_hunt();
            end else begin
               byte_sum    = byte_sum + rx;
               next_pos    = scfd_pkg::POS_LEN;
               parse_phase = scfd_pkg::PH_LEN;
            end
         end
         scfd_pkg::PH_LEN: begin
            res.emit          = 1'b1;
            res.byte_position = scfd_pkg::POS_LEN;
            shadow_len        = rx;
            if (rx > overhead_cfg && {1'b0, rx} < max_len_cfg && rx >= scfd_pkg::MIN_LEN) begin
               byte_sum    = byte_sum + rx;
               next_pos    = scfd_pkg::POS_BODY;
               parse_phase = scfd_pkg::PH_BODY;
            end else begin
               res.frame_abort = 1'b1;
               restart_hunt();
            end
         end
         default: begin
            res.emit          = 1'b1;
            res.byte_position = next_pos;
            if ({1'b0, next_pos} + 9'd1 >= {1'b0, shadow_len}) begin
               // Last byte carries the checksum and is not summed itself.
               res.frame_last  = 1'b1;
               res.checksum_ok = (rx == byte_sum);
               restart_hunt();
            end else begin
               byte_sum = byte_sum + rx;
               next_pos = next_pos + 8'd1;
            end
         end
      endcase
   endtask

   task automatic compare_result();
      scfd_pkg::result_type want;
      results_taken++;
      if (expected_frame_bytes.size() == 0) begin
         report_mismatch("result with nothing expected, frame_byte", rsp_frame_byte, 8'h00);
         return;
      end
      want = expected_frame_bytes.pop_front();
      if (rsp_frame_byte !== want.frame_byte)
         report_mismatch("frame_byte", rsp_frame_byte, want.frame_byte);
      if (rsp_byte_position !== want.byte_position)
         report_mismatch("byte_position", rsp_byte_position, want.byte_position);
      if (rsp_frame_last !== want.frame_last)
         report_mismatch("frame_last", {7'd0, rsp_frame_last}, {7'd0, want.frame_last});
      if (rsp_checksum_ok !== want.checksum_ok)
         report_mismatch("checksum_ok", {7'd0, rsp_checksum_ok}, {7'd0, want.checksum_ok});
      if (rsp_frame_abort !== want.frame_abort)
         report_mismatch("frame_abort", {7'd0, rsp_frame_abort}, {7'd0, want.frame_abort});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_hunt();
         shadow_len   = '0;
         overhead_cfg = scfd_pkg::FIXED_OVERHEAD_RST;
         max_len_cfg  = scfd_pkg::MAX_FRAME_LEN_RST;
         expected_frame_bytes.delete();
      end else begin
         // A result leaving now belongs to an earlier byte, so it is checked first.
         if (rsp_valid && rsp_ready) compare_result();
         if (req_valid && req_ready) begin
            bytes_taken++;
            advance_parser(req_rx_byte, predicted);
            if (predicted.emit) begin
               expected_frame_bytes.push_back(predicted);
               if (predicted.frame_abort) aborted_frames++;
               else if (predicted.frame_last && predicted.checksum_ok) good_frames++;
               else if (predicted.frame_last) bad_frames++;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == scfd_pkg::REG_MAX_FRAME_LEN) max_len_cfg = csr_pwdata[8:0];
            else overhead_cfg = csr_pwdata[7:0];
         end
      end
      pending_results <= expected_frame_bytes.size();
   end

endmodule

@@ test/tb_sum_checked_frame_deframer.sv @@
// Testbench top for the sum-checked frame deframer: stimulus, register settings and verdict.
`timescale 1ns / 100ps
module tb_sum_checked_frame_deframer;

   // Number of register settings the run steps through, and the random bytes sent under each.
   localparam int NUM_SETTINGS  = 9;
   localparam int BYTES_PER_SET = 55;
   // A byte passes the input register and then the result register; the settle time
   // also covers a byte that makes no result but may still sit in the input register.
   localparam int SETTLE_CYCLES = 6;
   // Far above the slowest correct run.
   localparam int CYCLE_LIMIT   = 1000000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [7:0]  rsp_frame_byte;
   logic [7:0]  rsp_byte_position;
   logic        rsp_frame_last;
   logic        rsp_checksum_ok;
   logic        rsp_frame_abort;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending_results;
   int bytes_taken;
   int results_taken;
   int good_frames;
   int bad_frames;
   int aborted_frames;

   int cycle_count;
   int sent_bytes;
   int stall_left;
   // While calm is set neither side idles, so full-rate stretches are part of the run.
   bit calm;

   // The length bounds as the block now holds them, used to shape the frames.
   logic [7:0] cfg_overhead;
   logic [8:0] cfg_max_len;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sum_checked_frame_deframer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_frame_abort   (rsp_frame_abort),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   scfd_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_last    (rsp_frame_last),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_frame_abort   (rsp_frame_abort),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .pending_results   (pending_results),
      .bytes_taken       (bytes_taken),
      .results_taken     (results_taken),
      .good_frames       (good_frames),
      .bad_frames        (bad_frames),
      .aborted_frames    (aborted_frames)
   );

   // Length of one idle stretch: mostly from the shortest range, sometimes the middle one, rarely long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic int sender_gap();
      if (calm || $urandom_range(0, 99) < 45) return 0;
      return idle_length();
   endfunction

   // Shortest length byte that the lower bounds of the block accept.
   function automatic int shortest_length();
      return (int'(cfg_overhead) + 1 > int'(scfd_pkg::MIN_LEN)) ? int'(cfg_overhead) + 1
                                                                : int'(scfd_pkg::MIN_LEN);
   endfunction

   // Picks an accepted frame length, mostly close to the shortest one so frames stay
   // short; returns zero when the bounds leave no accepted length at all.
   function automatic int pick_frame_size();
      int lo;
      int hi;
      lo = shortest_length();
      hi = (int'(cfg_max_len) - 1 < 255) ? int'(cfg_max_len) - 1 : 255;
      if (lo > hi) return 0;
      if ($urandom_range(0, 99) < 2) return hi;
      return lo + $urandom_range(0, (hi - lo < 8) ? hi - lo : 8);
   endfunction

   // A length byte the block must reject: either too short or not below the maximum.
   function automatic logic [7:0] rejected_length();
      if (cfg_max_len <= 9'd255 && $urandom_range(0, 1) == 1)
         return 8'($urandom_range(int'(cfg_max_len), 255));
      return 8'($urandom_range(0, shortest_length() - 1));
   endfunction

   // One transfer on the byte channel. Valid stays high into the next byte when no
   // gap follows, so back-to-back bytes never see valid drop between them.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_bytes++;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sends a whole frame: both header bytes, the length byte, length minus four body
   // bytes and then the checksum, which is the wrapping sum of all bytes before it.
   // With corrupt set, the checksum byte is flipped in at least one bit.
   task automatic send_frame(input logic [7:0] len, input bit corrupt);
      logic [7:0] sum;
      logic [7:0] body;
      int i;
      sum = scfd_pkg::HDR_FIRST + scfd_pkg::HDR_SECOND + len;
      send_byte(scfd_pkg::HDR_FIRST);
      send_byte(scfd_pkg::HDR_SECOND);
      send_byte(len);
      for (i = 4; i < int'(len); i++) begin
         body = 8'($urandom);
         sum  = sum + body;
         send_byte(body);
      end
      send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endtask

   // Register write over the APB-style port: setup cycle, access cycle, then release.
   // The unused upper data bits carry random values, which the block must drop.
   task automatic write_register(input logic idx, input logic [8:0] value);
      logic [31:0] wdata;
      wdata = $urandom;
      if (idx == scfd_pkg::REG_FIXED_OVERHEAD) wdata[7:0] = value[7:0];
      else wdata[8:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // The sender stops and waits until every predicted result has been taken, then
   // lets the pipeline settle so that the block is idle for a register write.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random traffic: mostly well-formed frames, some with a bad checksum, the rest line
   // noise, broken second headers and rejected length bytes.
   task automatic run_random_traffic(input int byte_goal);
      int start;
      int pick;
      int len;
      int i;
      start = sent_bytes;
      while (sent_bytes - start < byte_goal) begin
         if (calm) calm <= ($urandom_range(0, 99) < 70);
         else calm <= ($urandom_range(0, 99) < 8);
         pick = $urandom_range(0, 99);
         len  = pick_frame_size();
         if (pick < 65 && len > 0) begin
            send_frame(8'(len), 1'b0);
         end else if (pick < 78 && len > 0) begin
            send_frame(8'(len), 1'b1);
         end else if (pick < 86) begin
            for (i = 0; i < int'($urandom_range(1, 4)); i++) send_byte(8'($urandom));
         end else if (pick < 93) begin
            send_byte(scfd_pkg::HDR_FIRST);
            send_byte(8'($urandom));
         end else begin
            send_byte(scfd_pkg::HDR_FIRST);
            send_byte(scfd_pkg::HDR_SECOND);
            send_byte(rejected_length());
         end
      end
   endtask

   // Result side back-pressure: random stalls of the same length profile as the
   // sender's gaps, none while calm.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready  <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 99) < 25) begin
         rsp_ready  <= 1'b0;
         stall_left = idle_length() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: a run that stops making progress ends here as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results still expected.",
                  cycle_count, pending_results);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int k;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      calm        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < NUM_SETTINGS; k++) begin
         // Settings cover the reset values, both extremes of each bound, bounds that
         // reject every length, a maximum above 256, a window that admits only the
         // shortest possible frame, and random pairs.
         case (k)
            0: begin
               cfg_overhead = scfd_pkg::FIXED_OVERHEAD_RST;
               cfg_max_len  = scfd_pkg::MAX_FRAME_LEN_RST;
            end
            1: begin
               cfg_overhead = 8'd0;
               cfg_max_len  = 9'd256;
            end
            2: begin
               cfg_overhead = 8'd255;
               cfg_max_len  = 9'd256;
            end
            3: begin
               cfg_overhead = 8'd3;
               cfg_max_len  = 9'd1;
            end
            4: begin
               cfg_overhead = 8'd6;
               cfg_max_len  = 9'd511;
            end
            5: begin
               cfg_overhead = 8'd0;
               cfg_max_len  = 9'd5;
            end
            6: begin
               cfg_overhead = 8'($urandom_range(0, 60));
               cfg_max_len  = 9'($urandom_range(0, 511));
            end
            7: begin
               cfg_overhead = 8'd10;
               cfg_max_len  = 9'd20;
            end
            default: begin
               cfg_overhead = 8'($urandom_range(0, 30));
               cfg_max_len  = 9'($urandom_range(40, 300));
            end
         endcase
         write_register(scfd_pkg::REG_FIXED_OVERHEAD, {1'b0, cfg_overhead});
         write_register(scfd_pkg::REG_MAX_FRAME_LEN, cfg_max_len);

         if (k == 0) begin
            // Line noise at both ends of the byte range makes no result.
            send_byte(8'h00);
            send_byte(8'hFF);
            // A wrong second header byte aborts; a repeated first header byte in that
            // slot aborts as well and is not taken as the start of a new frame.
            send_byte(scfd_pkg::HDR_FIRST);
            send_byte(8'h00);
            send_byte(scfd_pkg::HDR_FIRST);
            send_byte(scfd_pkg::HDR_FIRST);
            // Length equal to the overhead, and length zero, are both rejected.
            send_byte(scfd_pkg::HDR_FIRST);
            send_byte(scfd_pkg::HDR_SECOND);
            send_byte(scfd_pkg::FIXED_OVERHEAD_RST);
            send_byte(scfd_pkg::HDR_FIRST);
            send_byte(scfd_pkg::HDR_SECOND);
            send_byte(8'd0);
            // Shortest accepted frame under reset bounds, once clean and once corrupted.
            send_frame(scfd_pkg::FIXED_OVERHEAD_RST + 8'd1, 1'b0);
            send_frame(scfd_pkg::FIXED_OVERHEAD_RST + 8'd1, 1'b1);
         end
         // With the maximum above 256 the longest length byte is accepted.
         if (k == 4) send_frame(8'd255, 1'b0);

         run_random_traffic(BYTES_PER_SET);
         wait_idle();
      end

      $display("Run summary: %0d bytes sent under %0d register settings, %0d results checked.",
               bytes_taken, NUM_SETTINGS, results_taken);
      $display("Run summary: %0d frames with a good checksum, %0d with a bad one, %0d aborts.",
               good_frames, bad_frames, aborted_frames);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
